>>> hw/rtl/postfix_stack_evaluator_unit_macros.svh
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication on i_clk, off while i_rst_n is low
`define PSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication on i_clk, off while i_rst_n is low
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> hw/rtl/pse_pkg.sv
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 5;
    localparam int OP_W        = 5;
    localparam int ERR_W       = 2;
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic signed [DATA_W-1:0] Q_ONE       = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_MINUS_ONE = 32'shFFFF_0000;
    localparam logic signed [DATA_W-1:0] Q_ZERO      = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN       = 32'sh8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 5'd0,
        OP_ADD     = 5'd1,
        OP_SUB     = 5'd2,
        OP_MUL     = 5'd3,
        OP_DIV     = 5'd4,
        OP_MOD     = 5'd5,
        OP_INC     = 5'd6,
        OP_DEC     = 5'd7,
        OP_LT      = 5'd8,
        OP_GT      = 5'd9,
        OP_LE      = 5'd10,
        OP_GE      = 5'd11,
        OP_EQ      = 5'd12,
        OP_NE      = 5'd13,
        OP_AND     = 5'd14,
        OP_OR      = 5'd15,
        OP_PUSH_M1 = 5'd16,
        OP_PUSH_P1 = 5'd17
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_ZERO  = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV
    } t_state;

    typedef struct packed {
        logic start;
        logic mod_mode;
    } t_div_ctl;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res = v[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] res;
        res = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return res;
    endfunction

endpackage

>>> hw/rtl/pse_div.sv
module pse_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pse_pkg::t_div_ctl            i_ctl,
    input  logic [pse_pkg::DATA_W-1:0]   i_dividend,
    input  logic [pse_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [pse_pkg::DATA_W-1:0]   o_quotient,
    output logic [pse_pkg::DATA_W-1:0]   o_remainder
);
    import pse_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_dsr;

    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    trial;
    logic                 take;

    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};
    assign take    = !trial[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            if (i_ctl.mod_mode) begin
                r_rem <= '0;
                r_quo <= {{FRAC_W{1'b0}}, i_dividend[DATA_W-1:FRAC_W]};
                r_dsr <= {{FRAC_W{1'b0}}, i_divisor[DATA_W-1:FRAC_W]};
            end else begin
                r_rem <= {{FRAC_W{1'b0}}, i_dividend[DATA_W-1:FRAC_W]};
                r_quo <= {i_dividend[FRAC_W-1:0], {FRAC_W{1'b0}}};
                r_dsr <= i_divisor;
            end
        end else if (r_run) begin
            r_rem <= take ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], take};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/postfix_stack_evaluator_unit.sv
// Push, inc, dec, add, sub, compare, and/or, unknown codes and every error finish
// straight from the execute state.
// Mul: one registered 32x32 product, then round and saturate.
// Div and mod run through the 32 steps of the shared restoring divider;
// a div whose quotient saturates skips the divider. Busy holds until the result
// strobe; results cannot be stalled. Synchronous active-low reset empties the stack.
module postfix_stack_evaluator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pse_pkg::OP_W-1:0]          i_operation,
    input  logic signed [pse_pkg::DATA_W-1:0] i_operand_value,
    output logic                              o_result_valid,
    output logic signed [pse_pkg::DATA_W-1:0] o_top_value,
    output logic [pse_pkg::CNT_W-1:0]         o_stack_count,
    output logic [pse_pkg::ERR_W-1:0]         o_error_code
);
    import pse_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]         r_sp, n_sp;
    logic signed [DATA_W-1:0] r_tos, n_tos;
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [2*DATA_W-1:0] r_prod;
    logic                     r_neg;
    logic                     r_is_mod;
    logic                     r_result_valid;
    logic signed [DATA_W-1:0] r_top;
    logic [CNT_W-1:0]         r_cnt;
    logic [ERR_W-1:0]         r_err;

    t_err                     n_err;
    logic                     result_fire;
    logic                     mem_we;
    t_div_ctl                 div_ctl;
    logic                     div_done;
    logic [DATA_W-1:0]        div_quo;
    logic [DATA_W-1:0]        div_rem;

    logic                     accept;
    logic [CNT_W-1:0]         sp_m1;
    logic [CNT_W-1:0]         sp_m2;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
    logic [DATA_W-1:0]        l_mag;
    logic [DATA_W-1:0]        r_mag;
    logic signed [DATA_W:0]   add_sum;
    logic signed [DATA_W:0]   sub_diff;
    logic signed [DATA_W:0]   inc_sum;
    logic signed [DATA_W:0]   dec_diff;
    logic signed [2*DATA_W-1:0] mul_full;
    logic signed [DATA_W-1:0] mul_res;
    logic signed [DATA_W-1:0] div_res;
    logic signed [DATA_W-1:0] mod_res;
    logic signed [DATA_W-1:0] div_sat;
    logic signed [DATA_W-1:0] push_val;
    logic [DATA_W-1:0]        mod_mag;
    logic                     is_push;
    logic                     is_step;
    logic                     is_bin;
    logic                     sp_full;
    logic                     sp_empty;
    logic                     sp_lt2;
    logic                     div_zero;
    logic                     mod_zero;
    logic                     div_ovf;
    logic                     go_mul;
    logic                     go_div;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign sp_m1    = r_sp - CNT_W'(1);
    assign sp_m2    = r_sp - CNT_W'(2);
    assign left     = r_rd_data;
    assign right    = r_tos;
    assign l_mag    = mag32(left);
    assign r_mag    = mag32(right);
    assign add_sum  = (DATA_W+1)'(left) + (DATA_W+1)'(right);
    assign sub_diff = (DATA_W+1)'(left) - (DATA_W+1)'(right);
    assign inc_sum  = (DATA_W+1)'(r_tos) + (DATA_W+1)'(Q_ONE);
    assign dec_diff = (DATA_W+1)'(r_tos) - (DATA_W+1)'(Q_ONE);
    assign mul_full = left * right;

    assign mul_res = (r_prod[2*DATA_W-1:DATA_W+FRAC_W-1]
                      == {(DATA_W-FRAC_W+1){r_prod[2*DATA_W-1]}})
                     ? r_prod[DATA_W+FRAC_W-1:FRAC_W]
                     : (r_prod[2*DATA_W-1] ? Q_MIN : Q_MAX);

    always_comb begin
        if (r_neg) begin
            div_res = (div_quo > DATA_W'(Q_MIN)) ? Q_MIN : DATA_W'(-div_quo);
        end else begin
            div_res = div_quo[DATA_W-1] ? Q_MAX : DATA_W'(div_quo);
        end
    end

    assign mod_mag  = {div_rem[FRAC_W-1:0], {FRAC_W{1'b0}}};
    assign mod_res  = r_neg ? DATA_W'(-mod_mag) : DATA_W'(mod_mag);
    assign div_sat  = (left[DATA_W-1] ^ right[DATA_W-1]) ? Q_MIN : Q_MAX;

    assign is_push  = (r_op == OP_PUSH) || (r_op == OP_PUSH_M1) || (r_op == OP_PUSH_P1);
    assign is_step  = (r_op == OP_INC) || (r_op == OP_DEC);
    assign is_bin   = (r_op >= OP_ADD) && (r_op <= OP_OR) && !is_step;
    assign push_val = (r_op == OP_PUSH) ? r_val
                    : ((r_op == OP_PUSH_M1) ? Q_MINUS_ONE : Q_ONE);
    assign sp_full  = (r_sp == CNT_W'(STACK_DEPTH));
    assign sp_empty = (r_sp == '0);
    assign sp_lt2   = (r_sp < CNT_W'(2));
    assign div_zero = (right == Q_ZERO);
    assign mod_zero = (r_mag[DATA_W-1:FRAC_W] == '0);
    assign div_ovf  = ({{FRAC_W{1'b0}}, l_mag[DATA_W-1:FRAC_W]} >= r_mag);
    assign go_mul   = is_bin && !sp_lt2 && (r_op == OP_MUL);
    assign go_div   = is_bin && !sp_lt2
                      && (((r_op == OP_DIV) && !div_zero && !div_ovf)
                          || ((r_op == OP_MOD) && !mod_zero));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go_mul) begin
                    n_state = S_MUL;
                end else if (go_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_sp         = r_sp;
        n_tos        = r_tos;
        n_err        = ERR_OK;
        result_fire  = 1'b0;
        mem_we       = 1'b0;
        div_ctl      = '0;
        unique case (r_state)
            S_EXEC: begin
                priority if (is_push) begin
                    result_fire = 1'b1;
                    if (sp_full) begin
                        n_err = ERR_OVER;
                    end else begin
                        mem_we = !sp_empty;
                        n_tos  = push_val;
                        n_sp   = r_sp + CNT_W'(1);
                    end
                end else if (is_step) begin
                    result_fire = 1'b1;
                    if (sp_empty) begin
                        n_err = ERR_UNDER;
                    end else begin
                        n_tos = sat33((r_op == OP_INC) ? inc_sum : dec_diff);
                    end
                end else if (is_bin) begin
                    if (sp_lt2) begin
                        result_fire = 1'b1;
                        n_err       = ERR_UNDER;
                    end else begin
                        unique case (r_op)
                            OP_ADD: begin
                                result_fire = 1'b1;
                                n_tos       = sat33(add_sum);
                                n_sp        = sp_m1;
                            end
                            OP_SUB: begin
                                result_fire = 1'b1;
                                n_tos       = sat33(sub_diff);
                                n_sp        = sp_m1;
                            end
                            OP_MUL: begin
                                result_fire = 1'b0;
                            end
                            OP_DIV: begin
                                if (div_zero) begin
                                    result_fire = 1'b1;
                                    n_err       = ERR_ZERO;
                                end else if (div_ovf) begin
                                    result_fire = 1'b1;
                                    n_tos       = div_sat;
                                    n_sp        = sp_m1;
                                end else begin
                                    div_ctl.start = 1'b1;
                                end
                            end
                            OP_MOD: begin
                                if (mod_zero) begin
                                    result_fire = 1'b1;
                                    n_err       = ERR_ZERO;
                                end else begin
                                    div_ctl.start    = 1'b1;
                                    div_ctl.mod_mode = 1'b1;
                                end
                            end
                            OP_LT: begin
                                result_fire = 1'b1;
                                n_tos       = (left < right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_GT: begin
                                result_fire = 1'b1;
                                n_tos       = (left > right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_LE: begin
                                result_fire = 1'b1;
                                n_tos       = (left <= right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_GE: begin
                                result_fire = 1'b1;
                                n_tos       = (left >= right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_EQ: begin
                                result_fire = 1'b1;
                                n_tos       = (left == right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_NE: begin
                                result_fire = 1'b1;
                                n_tos       = (left != right) ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            OP_AND: begin
                                result_fire = 1'b1;
                                n_tos       = ((left == Q_ONE) && (right == Q_ONE))
                                              ? Q_ONE : Q_ZERO;
                                n_sp        = sp_m1;
                            end
                            default: begin
                                result_fire = 1'b1;
                                n_tos       = ((left == Q_ZERO) && (right == Q_ZERO))
                                              ? Q_ZERO : Q_ONE;
                                n_sp        = sp_m1;
                            end
                        endcase
                    end
                end else begin
                    result_fire = 1'b1;
                end
            end
            S_MUL: begin
                result_fire = 1'b1;
                n_tos       = mul_res;
                n_sp        = sp_m1;
            end
            S_DIV: begin
                if (div_done) begin
                    result_fire = 1'b1;
                    n_tos       = r_is_mod ? mod_res : div_res;
                    n_sp        = sp_m1;
                end
            end
            default: begin
                result_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sp           <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sp           <= n_sp;
            r_result_valid <= result_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= n_tos;
        if (accept) begin
            r_op  <= i_operation;
            r_val <= i_operand_value;
        end
        if (r_state == S_EXEC) begin
            r_prod   <= mul_full;
            r_is_mod <= (r_op == OP_MOD);
            r_neg    <= (r_op == OP_MOD) ? left[DATA_W-1]
                                         : (left[DATA_W-1] ^ right[DATA_W-1]);
        end
        if (result_fire) begin
            r_top <= (n_sp == '0) ? Q_ZERO : n_tos;
            r_cnt <= n_sp;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[sp_m1[ADDR_W-1:0]] <= r_tos;
        end
        r_rd_data <= r_mem[sp_m2[ADDR_W-1:0]];
    end

    pse_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (l_mag),
        .i_divisor   (r_mag),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_result_valid = r_result_valid;
    assign o_top_value    = r_top;
    assign o_stack_count  = r_cnt;
    assign o_error_code   = r_err;

endmodule

>>> hw/rtl/pse_checker.sv
`include "postfix_stack_evaluator_unit_macros.svh"

module pse_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic signed [pse_pkg::DATA_W-1:0] o_top_value,
    input logic [pse_pkg::CNT_W-1:0]         o_stack_count,
    input logic [pse_pkg::ERR_W-1:0]         o_error_code
);
    import pse_pkg::*;

    `PSE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PSE_ASSERT_NOW(a_done_strobe, $fell(busy) && $past(i_rst_n), o_result_valid)
    `PSE_ASSERT_NOW(a_strobe_idle, o_result_valid, !busy)
    `PSE_ASSERT_NOW(a_empty_top, o_result_valid && (o_stack_count == '0), o_top_value == Q_ZERO)
    `PSE_ASSERT_NOW(a_over_full, o_result_valid && (o_error_code == ERR_OVER), o_stack_count == CNT_W'(STACK_DEPTH))

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_top_value    (o_top_value),
    .o_stack_count  (o_stack_count),
    .o_error_code   (o_error_code)
);

>>> tb/postfix_stack_evaluator_unit_checker.sv
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit_checker
    import pse_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_operand_value,
    input  logic                     i_result_valid,
    input  logic signed [DATA_W-1:0] i_top_value,
    input  logic [CNT_W-1:0]         i_stack_count,
    input  logic [ERR_W-1:0]         i_error_code,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] top;
        logic [CNT_W-1:0]         count;
        logic [ERR_W-1:0]         err;
    } t_stack_view;

    t_stack_view              awaited_views[$];
    logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                       shadow_depth;
    int                       fails;

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
        logic signed [DATA_W-1:0] res;
        if (v > longint'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < longint'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = DATA_W'(v);
        end
        return res;
    endfunction

    function automatic t_stack_view advance_stack(input logic [OP_W-1:0] op,
                                                  input logic signed [DATA_W-1:0] val);
        longint                   lhs;
        longint                   rhs;
        longint                   lhs_int;
        longint                   rhs_int;
        logic signed [DATA_W-1:0] answer;
        t_err                     code;
        t_stack_view              view;
        code = ERR_OK;
        case (op)
            OP_PUSH, OP_PUSH_M1, OP_PUSH_P1: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    code = ERR_OVER;
                end else begin
                    shadow_stack[ADDR_W'(shadow_depth)] = (op == OP_PUSH)    ? val :
                                                 (op == OP_PUSH_M1) ? Q_MINUS_ONE : Q_ONE;
                    shadow_depth++;
                end
            end
            OP_INC, OP_DEC: begin
                if (shadow_depth == 0) begin
                    code = ERR_UNDER;
                end else begin
                    lhs = longint'(shadow_stack[ADDR_W'(shadow_depth-1)]);
                    shadow_stack[ADDR_W'(shadow_depth-1)] = clamp_q((op == OP_INC) ?
                        lhs + longint'(Q_ONE) : lhs - longint'(Q_ONE));
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_LE,
            OP_GE, OP_EQ, OP_NE, OP_AND, OP_OR: begin
                if (shadow_depth < 2) begin
                    code = ERR_UNDER;
                end else begin
                    rhs    = longint'(shadow_stack[ADDR_W'(shadow_depth-1)]);
                    lhs    = longint'(shadow_stack[ADDR_W'(shadow_depth-2)]);
                    answer = Q_ZERO;
                    case (op)
                        OP_ADD: answer = clamp_q(lhs + rhs);
                        OP_SUB: answer = clamp_q(lhs - rhs);
                        OP_MUL: answer = clamp_q((lhs * rhs) >>> FRAC_W);
                        OP_DIV: begin
                            if (rhs == 0) begin
                                code = ERR_ZERO;
                            end else begin
                                answer = clamp_q((lhs * longint'(Q_ONE)) / rhs);
                            end
                        end
                        OP_MOD: begin
                            lhs_int = lhs / longint'(Q_ONE);
                            rhs_int = rhs / longint'(Q_ONE);
                            if (rhs_int == 0) begin
                                code = ERR_ZERO;
                            end else begin
                                answer = clamp_q((lhs_int % rhs_int) * longint'(Q_ONE));
                            end
                        end
                        OP_LT:  answer = (lhs <  rhs) ? Q_ONE : Q_ZERO;
                        OP_GT:  answer = (lhs >  rhs) ? Q_ONE : Q_ZERO;
                        OP_LE:  answer = (lhs <= rhs) ? Q_ONE : Q_ZERO;
                        OP_GE:  answer = (lhs >= rhs) ? Q_ONE : Q_ZERO;
                        OP_EQ:  answer = (lhs == rhs) ? Q_ONE : Q_ZERO;
                        OP_NE:  answer = (lhs != rhs) ? Q_ONE : Q_ZERO;
                        OP_AND: answer = (lhs == longint'(Q_ONE) && rhs == longint'(Q_ONE)) ?
                                         Q_ONE : Q_ZERO;
                        default: answer = (lhs == 0 && rhs == 0) ? Q_ZERO : Q_ONE;
                    endcase
                    if (code == ERR_OK) begin
                        shadow_depth--;
                        shadow_stack[ADDR_W'(shadow_depth-1)] = answer;
                    end
                end
            end
            default: ;
        endcase
        view.top   = (shadow_depth == 0) ? Q_ZERO : shadow_stack[ADDR_W'(shadow_depth-1)];
        view.count = CNT_W'(shadow_depth);
        view.err   = code;
        return view;
    endfunction

    always @(posedge i_clk) begin
        t_stack_view due;
        if (!i_rst_n) begin
            shadow_depth = 0;
            awaited_views.delete();
        end else begin
            // check the result before queuing the transfer taken at this edge
            if (i_result_valid) begin
                if (awaited_views.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result top=%h count=%0d err=%0d",
                             $time, i_top_value, i_stack_count, i_error_code);
                end else begin
                    due = awaited_views.pop_front();
                    if (i_top_value !== due.top) begin
                        fails++;
                        $display("%0t: top_value expected %h actual %h",
                                 $time, due.top, i_top_value);
                    end
                    if (i_stack_count !== due.count) begin
                        fails++;
                        $display("%0t: stack_count expected %0d actual %0d",
                                 $time, due.count, i_stack_count);
                    end
                    if (i_error_code !== due.err) begin
                        fails++;
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, due.err, i_error_code);
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_views.push_back(advance_stack(i_operation, i_operand_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_views.size();
    end

endmodule

>>> tb/postfix_stack_evaluator_unit_tb.sv
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit_tb;
    import pse_pkg::*;

    localparam int              RANDOM_ITEMS   = 1200;
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 5'd18;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 5'd31;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_operand_value;
    logic                     o_result_valid;
    logic signed [DATA_W-1:0] o_top_value;
    logic [CNT_W-1:0]         o_stack_count;
    logic [ERR_W-1:0]         o_error_code;
    int                       fail_count;
    int                       pending;
    int                       burst_left;

    postfix_stack_evaluator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_operand_value (i_operand_value),
        .o_result_valid  (o_result_valid),
        .o_top_value     (o_top_value),
        .o_stack_count   (o_stack_count),
        .o_error_code    (o_error_code)
    );

    postfix_stack_evaluator_unit_checker step_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_operation     (i_operation),
        .i_operand_value (i_operand_value),
        .i_result_valid  (o_result_valid),
        .i_top_value     (o_top_value),
        .i_stack_count   (o_stack_count),
        .i_error_code    (o_error_code),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_operand();
        int                       k;
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4: begin
                k = int'($urandom_range(0, 40)) - 20;
                v = k * Q_ONE;
            end
            5: v = Q_ONE;
            6: v = Q_ZERO;
            7: v = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            8: begin
                k = int'($urandom_range(0, 524288)) - 262144;
                v = k;
            end
            default: v = Q_MINUS_ONE;
        endcase
        return v;
    endfunction

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        start           <= 1'b1;
        i_operation     <= op;
        i_operand_value <= val;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [OP_W-1:0] op;
        int              phase_left;
        bit              filling;
        int              roll;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_operation     <= OP_PUSH;
        i_operand_value <= Q_ZERO;
        burst_left      = 0;
        phase_left      = 0;
        filling         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_INC, Q_ZERO);
        issue(OP_ADD, Q_ZERO);
        issue(OP_PUSH, Q_MAX);
        issue(OP_MUL, Q_ZERO);
        issue(OP_INC, Q_ZERO);
        issue(OP_PUSH, Q_MAX);
        issue(OP_ADD, Q_ZERO);
        issue(OP_PUSH, Q_MIN);
        issue(OP_SUB, Q_ZERO);
        issue(OP_PUSH_M1, Q_ZERO);
        issue(OP_MUL, Q_ZERO);
        issue(OP_DEC, Q_ZERO);
        issue(OP_PUSH, Q_ZERO);
        issue(OP_DIV, Q_ZERO);
        issue(OP_MOD, Q_ZERO);
        issue(OP_AND, Q_ZERO);
        issue(OP_PUSH_P1, Q_ZERO);
        issue(OP_OR, Q_ZERO);
        issue(OP_PUSH_M1, Q_ZERO);
        issue(OP_DIV, Q_ZERO);
        issue(OP_PUSH, 32'sh0007_8000);
        issue(OP_MOD, Q_ZERO);
        for (int c = OP_LT; c <= OP_NE; c++) begin
            issue(OP_PUSH, pick_operand());
            issue(OP_W'(c), Q_ZERO);
        end
        issue(OP_RESERVED_LO, Q_MAX);
        issue(OP_RESERVED_HI, Q_MIN);
        settle();

        // alternate fill and drain phases so the stack swings between empty and full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 50);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            end else if (roll < (filling ? 70 : 25)) begin
                case ($urandom_range(0, 9))
                    0:       op = OP_PUSH_M1;
                    1:       op = OP_PUSH_P1;
                    default: op = OP_PUSH;
                endcase
            end else if (roll < (filling ? 76 : 33)) begin
                op = $urandom_range(0, 1) ? OP_INC : OP_DEC;
            end else begin
                op = OP_W'($urandom_range(OP_ADD, OP_OR));
                if (op == OP_INC || op == OP_DEC) begin
                    op = OP_W'($urandom_range(OP_LT, OP_OR));
                end
            end
            issue(op, pick_operand());
            if (n == RANDOM_ITEMS / 2) begin
                settle();
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
